// ===== hdl/nsi_pkg.sv =====
package nsi_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int PHASE_BITS  = 24;
  localparam int INDEX_BITS  = 8;
  localparam int FRAC_BITS   = PHASE_BITS - INDEX_BITS;
  localparam int TABLE_DEPTH = 1 << INDEX_BITS;
  localparam int CFG_BITS    = 27;
  localparam int PERIOD_BITS = 32;
  localparam int OP_BITS     = 2;
  localparam int VALUE_BITS  = 16;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(5000);

  localparam logic [OP_BITS-1:0] OP_PERIOD = 2'd0;
  localparam logic [OP_BITS-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_WRITE  = 2'd2;

  // The dividend is the register value followed by PHASE_BITS zero bits.
  localparam int DIV_STEPS = CFG_BITS + PHASE_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);

endpackage

// ===== hdl/nco_sine_interpolator.sv =====
// Numerically controlled oscillator with a 256-entry sine table and linear
// interpolation between neighboring entries. A period word (op 0) sets the phase
// step to sample_period_ticks * 2^24 / period_count, low 24 bits kept; a zero
// period is ignored. It runs through one restoring divider that settles one
// quotient bit per cycle, so the block is busy until all quotient bits are settled.
// A tick word (op 1) reads two entries from the table memory in consecutive
// cycles, multiplies once and adds or subtracts once, and forms its result in
// its final state, which waits until the output register is free. A table-write
// word (op 2) does not make the block busy. Table entries must be written
// before a tick reads them. The user must write the configuration register only
// while the block is idle; the block itself does not enforce this.
module nco_sine_interpolator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nsi_pkg::CFG_BITS-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [nsi_pkg::OP_BITS-1:0]     op_i,
  input  logic [nsi_pkg::PERIOD_BITS-1:0] period_count_i,
  input  logic [nsi_pkg::INDEX_BITS-1:0]  table_index_i,
  input  logic [nsi_pkg::VALUE_BITS-1:0]  table_value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nsi_pkg::SAMPLE_BITS-1:0] sample_value_o,
  output logic [nsi_pkg::PHASE_BITS-1:0]  phase_out_o
);
  import nsi_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_RD_LO = 3'd2;
  localparam logic [2:0] S_RD_HI = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

  logic [2:0]               state_q, state_d;
  logic [CFG_BITS-1:0]      cfg_q;
  logic [PHASE_BITS-1:0]    phase_q, phase_d;
  logic [PHASE_BITS-1:0]    step_q, step_d;
  logic [CNT_BITS-1:0]      cnt_q, cnt_d;
  logic [CFG_BITS-1:0]      dvd_q, dvd_d;
  logic [PERIOD_BITS-1:0]   dvs_q, dvs_d;
  logic [PERIOD_BITS-1:0]   rem_q, rem_d;
  logic [PHASE_BITS-1:0]    quo_q, quo_d;
  logic [SAMPLE_BITS-1:0]   lo_q, lo_d;
  logic [SAMPLE_BITS-1:0]   diff_q, diff_d;
  logic                     neg_q, neg_d;
  logic [SAMPLE_BITS+FRAC_BITS-1:0] prod_q, prod_d;
  logic                     out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]   sample_q, sample_d;
  logic [PHASE_BITS-1:0]    phase_out_q, phase_out_d;

  logic [SAMPLE_BITS-1:0]   mem [TABLE_DEPTH];
  logic [SAMPLE_BITS-1:0]   rd_data_q;
  logic [INDEX_BITS-1:0]    rd_addr;
  logic [INDEX_BITS-1:0]    phase_idx;
  logic [FRAC_BITS-1:0]     phase_frac;

  logic                     accept;
  logic                     mem_we;
  logic [PERIOD_BITS:0]     shifted;
  logic                     ge;
  logic [PERIOD_BITS:0]     sub;
  logic [SAMPLE_BITS-1:0]   interp;
  logic                     out_free;

  assign phase_idx  = phase_q[PHASE_BITS-1:FRAC_BITS];
  assign phase_frac = phase_q[FRAC_BITS-1:0];
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign mem_we     = accept && (op_i == OP_WRITE);
  assign rd_addr    = (state_q == S_IDLE) ? phase_idx : phase_idx + INDEX_BITS'(1);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Divider step: shift in the next dividend bit and try to subtract.
  assign shifted = {rem_q, dvd_q[CFG_BITS-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign sub     = shifted - {1'b0, dvs_q};

  assign interp = neg_q ? lo_q - prod_q[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS]
                        : lo_q + prod_q[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[table_index_i] <= table_value_i[SAMPLE_BITS-1:0];
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    lo_d        = lo_q;
    diff_d      = diff_q;
    neg_d       = neg_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    sample_d    = sample_q;
    phase_out_d = phase_out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_PERIOD: begin
              if (period_count_i != '0) begin
                dvd_d   = cfg_q;
                dvs_d   = period_count_i;
                rem_d   = '0;
                quo_d   = '0;
                cnt_d   = '0;
                state_d = S_DIV;
              end
            end
            OP_TICK: begin
              state_d = S_RD_LO;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV: begin
        rem_d = ge ? sub[PERIOD_BITS-1:0] : shifted[PERIOD_BITS-1:0];
        quo_d = {quo_q[PHASE_BITS-2:0], ge};
        dvd_d = {dvd_q[CFG_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == CNT_LAST) begin
          step_d  = quo_d;
          state_d = S_IDLE;
        end
      end
      S_RD_LO: begin
        lo_d    = rd_data_q;
        state_d = S_RD_HI;
      end
      S_RD_HI: begin
        neg_d   = (rd_data_q < lo_q);
        diff_d  = (rd_data_q < lo_q) ? lo_q - rd_data_q : rd_data_q - lo_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        prod_d  = (SAMPLE_BITS+FRAC_BITS)'(diff_q) * (SAMPLE_BITS+FRAC_BITS)'(phase_frac);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          sample_d    = interp;
          phase_out_d = phase_q;
          phase_d     = phase_q + step_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= CFG_RESET;
      phase_q     <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    dvs_q       <= dvs_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    lo_q        <= lo_d;
    diff_q      <= diff_d;
    neg_q       <= neg_d;
    prod_q      <= prod_d;
    sample_q    <= sample_d;
    phase_out_q <= phase_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign sample_value_o = sample_q;
  assign phase_out_o    = phase_out_q;

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("Result word appeared outside the final tick step.");

  a_phase_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(phase_q) |-> $past(state_q) == S_FIN && out_valid_q)
    else $error("Phase advanced without issuing a result word.");

  a_step_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(step_q) |-> $past(state_q) == S_DIV && $past(cnt_q) == CNT_LAST)
    else $error("Phase step changed before the division finished.");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> cnt_q <= CNT_LAST)
    else $error("Division step counter ran past the last step.");

endmodule

// ===== bench/nco_sine_interpolator_test.sv =====
`timescale 1ns / 1ps

module nco_sine_interpolator_test;
  import nsi_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 5000;
  localparam int SEGMENT_WORDS = 330;
  localparam int SEGMENTS = 6;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [PHASE_BITS-1:0]  phase;
  } nco_sample_t;

  class nco_shadow;
    logic [CFG_BITS-1:0]    ticks;
    logic [PHASE_BITS-1:0]  phase;
    logic [PHASE_BITS-1:0]  step;
    logic [SAMPLE_BITS-1:0] sine_lut [TABLE_DEPTH];
    nco_sample_t            pending_samples[$];
    int                     errors;

    function new();
      ticks = CFG_RESET;
      phase = '0;
      step = '0;
      errors = 0;
      foreach (sine_lut[i]) sine_lut[i] = '0;
    endfunction

    function logic [SAMPLE_BITS-1:0] interpolate(logic [PHASE_BITS-1:0] ph);
      logic [INDEX_BITS-1:0]  idx;
      logic [SAMPLE_BITS-1:0] lo;
      logic [SAMPLE_BITS-1:0] hi;
      logic [63:0]            prod;
      idx = ph[PHASE_BITS-1:FRAC_BITS];
      lo = sine_lut[idx];
      hi = sine_lut[INDEX_BITS'(idx + 1)];
      if (hi >= lo) begin
        prod = 64'(hi - lo) * 64'(ph[FRAC_BITS-1:0]);
        return lo + SAMPLE_BITS'(prod >> FRAC_BITS);
      end else begin
        prod = 64'(lo - hi) * 64'(ph[FRAC_BITS-1:0]);
        return lo - SAMPLE_BITS'(prod >> FRAC_BITS);
      end
    endfunction

    function void take_word(logic [OP_BITS-1:0] op, logic [PERIOD_BITS-1:0] period,
                            logic [INDEX_BITS-1:0] idx, logic [VALUE_BITS-1:0] value);
      logic [CFG_BITS+PHASE_BITS-1:0] num;
      nco_sample_t                    next;
      case (op)
        OP_PERIOD: begin
          if (period != '0) begin
            num = {ticks, {PHASE_BITS{1'b0}}};
            step = PHASE_BITS'(num / period);
          end
        end
        OP_TICK: begin
          next.sample = interpolate(phase);
          next.phase = phase;
          pending_samples.push_back(next);
          phase = phase + step;
        end
        OP_WRITE: begin
          sine_lut[idx] = value[SAMPLE_BITS-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void check_sample(logic [SAMPLE_BITS-1:0] sample, logic [PHASE_BITS-1:0] ph);
      nco_sample_t want;
      if (pending_samples.size() == 0) begin
        errors++;
        $display("%0t: sample word with none outstanding: sample %h phase %h",
                 $time, sample, ph);
        return;
      end
      want = pending_samples.pop_front();
      if (want.sample !== sample) begin
        errors++;
        $display("%0t: sample_value expected %h actual %h", $time, want.sample, sample);
      end
      if (want.phase !== ph) begin
        errors++;
        $display("%0t: phase_out expected %h actual %h", $time, want.phase, ph);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_BITS-1:0]    cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [OP_BITS-1:0]     op_i = OP_PERIOD;
  logic [PERIOD_BITS-1:0] period_count_i = '0;
  logic [INDEX_BITS-1:0]  table_index_i = '0;
  logic [VALUE_BITS-1:0]  table_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [SAMPLE_BITS-1:0] sample_value_o;
  logic [PHASE_BITS-1:0]  phase_out_o;

  nco_shadow shadow = new();
  int sender_pct = 13;
  int receiver_pct = 72;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  nco_sine_interpolator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .period_count_i(period_count_i),
    .table_index_i (table_index_i),
    .table_value_i (table_value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sample_value_o(sample_value_o),
    .phase_out_o   (phase_out_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        shadow.take_word(op_i, period_count_i, table_index_i, table_value_i);
      end
      if (out_valid_o && !out_stall_i) begin
        shadow.check_sample(sample_value_o, phase_out_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      out_stall_i <= 1'b1;
      holds_served <= holds_served + 1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [OP_BITS-1:0] op, input logic [PERIOD_BITS-1:0] period,
                           input logic [INDEX_BITS-1:0] idx,
                           input logic [VALUE_BITS-1:0] value);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    period_count_i <= period;
    table_index_i <= idx;
    table_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  function automatic logic [PERIOD_BITS-1:0] pick_period();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(1, 255);
      2: return '0;
      3: return PERIOD_BITS'(shadow.ticks * $urandom_range(1, 64));
      default: return $urandom_range(1, 1 << 20);
    endcase
  endfunction

  task automatic send_random_word();
    int                 pick;
    logic [OP_BITS-1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 55) op = OP_TICK;
    else if (pick < 80) op = OP_WRITE;
    else if (pick < 95) op = OP_PERIOD;
    else op = OP_UNUSED;
    send_word(op, (op == OP_PERIOD) ? pick_period() : PERIOD_BITS'($urandom()),
              INDEX_BITS'($urandom()), VALUE_BITS'($urandom()));
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (shadow.pending_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ticks(input logic [CFG_BITS-1:0] value);
    drain_block();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.ticks = value;
  endtask

  initial begin
    logic [CFG_BITS-1:0] ticks_plan [SEGMENTS];
    logic [VALUE_BITS-1:0] fill;
    ticks_plan = '{CFG_BITS'(0), CFG_BITS'(1), CFG_BITS'(100000000), {CFG_BITS{1'b1}},
                   CFG_BITS'($urandom_range(1, 100000000)),
                   CFG_BITS'($urandom_range(1, 100000000))};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The whole table is loaded first so that every tick reads written entries.
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i < 8 || i >= TABLE_DEPTH - 8) fill = (i % 2 == 0) ? '1 : '0;
      else fill = VALUE_BITS'($urandom());
      send_word(OP_WRITE, $urandom(), INDEX_BITS'(i), fill);
    end

    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_UNUSED, '1, '1, '1);
    send_word(OP_PERIOD, '0, '0, '0);
    send_word(OP_TICK, '1, '1, '1);
    send_word(OP_PERIOD, '1, '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_PERIOD, PERIOD_BITS'(1), '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_PERIOD, PERIOD_BITS'(3), '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_WRITE, '0, '1, '0);
    send_word(OP_WRITE, '0, '0, '1);
    send_word(OP_PERIOD, PERIOD_BITS'(255), '0, '0);
    send_word(OP_TICK, '0, '0, '0);
    send_word(OP_TICK, '0, '0, '0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 2) begin
        sender_pct = 13;
        receiver_pct = 72;
      end else if (seg < 4) begin
        sender_pct = 72;
        receiver_pct = 13;
      end else begin
        sender_pct = 0;
        receiver_pct = 0;
      end
      write_ticks(ticks_plan[seg]);
      for (int n = 0; n < SEGMENT_WORDS; n++) begin
        if (seg == 4 && n == 60) hold_requests++;
        if (seg == 5 && n == 150) drain_block();
        send_random_word();
      end
    end

    drain_block();
    if (shadow.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nsi_pkg.sv
hdl/nco_sine_interpolator.sv
bench/nco_sine_interpolator_test.sv
